>>> rtl/cabn_pkg.sv
// Shared widths and constants for the class-aware box suppression block.
package cabn_pkg;

    localparam int CLASS_W = 8;
    localparam int SCORE_W = 16;
    localparam int ARR_W   = 10;

    localparam int RESULT_LIMIT = 64;
    localparam int EMIT_W       = $clog2(RESULT_LIMIT + 1);

    localparam logic [ARR_W-1:0]   ARRIVAL_MAX  = '1;
    localparam logic [SCORE_W-1:0] THRESH_RESET = SCORE_W'(29492);

endpackage

>>> rtl/cabn_ram.sv
// Generic single-write, single-read RAM with registered read data.
module cabn_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/cabn_mul.sv
// Shared signed multiplier with registered product, used for all box areas.
module cabn_mul #(
    parameter int W = 13
) (
    input  logic                  aclk,
    input  logic signed [W-1:0]   mul_a,
    input  logic signed [W-1:0]   mul_b,
    output logic signed [2*W-1:0] mul_p
);

    logic signed [2*W-1:0] prod_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
    end

    assign mul_p = prod_reg;

endmodule

>>> rtl/class_aware_box_nms_core.sv
// Class-aware non-maximum suppression core: box store, pairwise sequencer, result output.
// Load: one box per cycle while s_ready is high; s_ready drops after the last box of a set.
// Pairwise pass: each live slot i is read and its area taken, then each later live slot j, last
// first, is checked for class and overlap; a hit adds two multiplies and a compare.
// Output: each live slot is read, then emitted; an empty set gives one empty result; m_ready can stall.
// Reset (synchronous, active low) empties the set and restores the threshold; no clearing pass.
module class_aware_box_nms_core #(
    parameter int MAX_BOXES  = 64,
    parameter int COORD_BITS = 12
) (
    input  logic                           aclk,
    input  logic                           aresetn,

    input  logic                           cfg_we,
    input  logic [cabn_pkg::SCORE_W-1:0]   cfg_wdata,

    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [cabn_pkg::CLASS_W-1:0]   s_class_id,
    input  logic [COORD_BITS-1:0]          s_box_left,
    input  logic [COORD_BITS-1:0]          s_box_top,
    input  logic [COORD_BITS-1:0]          s_box_right,
    input  logic [COORD_BITS-1:0]          s_box_bottom,
    input  logic [cabn_pkg::SCORE_W-1:0]   s_confidence,
    input  logic                           s_last_item,

    output logic                           m_valid,
    input  logic                           m_ready,
    output logic                           m_result_valid,
    output logic [cabn_pkg::ARR_W-1:0]     m_arrival_index,
    output logic [cabn_pkg::CLASS_W-1:0]   m_out_class,
    output logic [COORD_BITS-1:0]          m_out_left,
    output logic [COORD_BITS-1:0]          m_out_top,
    output logic [COORD_BITS-1:0]          m_out_right,
    output logic [COORD_BITS-1:0]          m_out_bottom,
    output logic [cabn_pkg::SCORE_W-1:0]   m_out_confidence,
    output logic                           m_last_result,
    output logic                           m_overflow
);
    import cabn_pkg::*;

    localparam int IDX_W  = $clog2(MAX_BOXES);
    localparam int CNT_W  = $clog2(MAX_BOXES + 1);
    localparam int LIM_W  = (CNT_W > EMIT_W) ? CNT_W : EMIT_W;
    localparam int DIM_W  = COORD_BITS + 1;
    localparam int PROD_W = 2 * DIM_W;
    localparam int U_W    = PROD_W + 2;

    localparam logic [3:0] ST_LOAD    = 4'd0;
    localparam logic [3:0] ST_I_START = 4'd1;
    localparam logic [3:0] ST_I_LOAD  = 4'd2;
    localparam logic [3:0] ST_I_AREA  = 4'd3;
    localparam logic [3:0] ST_J_SEL   = 4'd4;
    localparam logic [3:0] ST_J_CHK   = 4'd5;
    localparam logic [3:0] ST_J_AREA  = 4'd6;
    localparam logic [3:0] ST_J_INT   = 4'd7;
    localparam logic [3:0] ST_I_END   = 4'd8;
    localparam logic [3:0] ST_E_SCAN  = 4'd9;
    localparam logic [3:0] ST_E_OUT   = 4'd10;
    localparam logic [3:0] ST_E_EMPTY = 4'd11;

    typedef struct packed {
        logic [ARR_W-1:0]      idx;
        logic [SCORE_W-1:0]    score;
        logic [CLASS_W-1:0]    cls;
        logic [COORD_BITS-1:0] bottom;
        logic [COORD_BITS-1:0] right;
        logic [COORD_BITS-1:0] top;
        logic [COORD_BITS-1:0] left;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    logic [3:0]           state_reg, state_next;
    logic [SCORE_W-1:0]   thresh_reg;
    logic [CNT_W-1:0]     kept_reg;
    logic [ARR_W-1:0]     arrival_reg;
    logic                 overflow_reg;
    logic [MAX_BOXES-1:0] alive_reg;
    logic [CNT_W-1:0]     live_reg;
    logic [CNT_W-1:0]     i_reg;
    logic [IDX_W-1:0]     j_reg;
    logic [CNT_W-1:0]     k_reg;
    logic [LIM_W-1:0]     n_reg;

    entry_t               cur_reg;
    entry_t               jd_reg;
    logic signed [PROD_W-1:0] area_i_reg;
    logic signed [PROD_W-1:0] area_j_reg;
    logic [COORD_BITS-1:0]    iw_reg;
    logic [COORD_BITS-1:0]    ih_reg;

    logic                 m_valid_reg;
    logic                 m_result_valid_reg;
    logic                 m_last_reg;
    logic                 m_ovf_reg;
    entry_t               m_entry_reg;

    // Load side
    logic                 s_accept;
    logic                 keep_box;
    logic                 store_box;
    logic [CNT_W-1:0]     kept_inc;
    entry_t               in_entry;

    // RAM
    logic                 ram_we;
    logic [IDX_W-1:0]     ram_waddr;
    entry_t               ram_wentry;
    logic                 ram_re;
    logic [IDX_W-1:0]     ram_raddr;
    logic [ENTRY_W-1:0]   ram_rdata;
    entry_t               rd_entry;

    // Pair geometry and compare
    logic [COORD_BITS-1:0]    ov_l, ov_t, ov_r, ov_b;
    logic                     pair_hit;
    logic signed [DIM_W-1:0]  mul_a, mul_b;
    logic signed [PROD_W-1:0] mul_p;
    logic signed [DIM_W-1:0]  rd_w, rd_h;
    logic signed [U_W-1:0]    uni, inter2;
    logic                     suppress;

    // Emit side
    logic                 out_free;
    logic                 m_load;
    logic [LIM_W-1:0]     live_ext;
    logic [LIM_W-1:0]     emit_lim;
    logic [LIM_W-1:0]     n_inc;

    assign s_ready   = (state_reg == ST_LOAD);
    assign s_accept  = s_valid && s_ready;
    assign keep_box  = (s_confidence >= thresh_reg);
    assign store_box = keep_box && (kept_reg < CNT_W'(MAX_BOXES));
    assign kept_inc  = kept_reg + CNT_W'(store_box);

    assign in_entry.idx    = arrival_reg;
    assign in_entry.score  = s_confidence;
    assign in_entry.cls    = s_class_id;
    assign in_entry.bottom = s_box_bottom;
    assign in_entry.right  = s_box_right;
    assign in_entry.top    = s_box_top;
    assign in_entry.left   = s_box_left;

    assign ram_we     = (s_accept && store_box) || (state_reg == ST_I_END);
    assign ram_waddr  = (state_reg == ST_LOAD) ? kept_reg[IDX_W-1:0] : i_reg[IDX_W-1:0];
    assign ram_wentry = (state_reg == ST_LOAD) ? in_entry : cur_reg;

    always_comb begin
        ram_re    = 1'b0;
        ram_raddr = j_reg;
        unique case (state_reg)
            ST_I_START: begin
                ram_re    = (i_reg < kept_reg) && alive_reg[i_reg[IDX_W-1:0]];
                ram_raddr = i_reg[IDX_W-1:0];
            end
            ST_J_SEL: begin
                ram_re    = (CNT_W'(j_reg) > i_reg) && alive_reg[j_reg];
                ram_raddr = j_reg;
            end
            ST_E_SCAN: begin
                ram_re    = (n_reg != emit_lim) && alive_reg[k_reg[IDX_W-1:0]];
                ram_raddr = k_reg[IDX_W-1:0];
            end
            default: begin
                ram_re    = 1'b0;
                ram_raddr = j_reg;
            end
        endcase
    end

    cabn_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(MAX_BOXES)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wentry),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    assign rd_entry = entry_t'(ram_rdata);

    // Overlap of slot i (held) and the slot just read
    assign ov_l = (cur_reg.left   > rd_entry.left)   ? cur_reg.left   : rd_entry.left;
    assign ov_t = (cur_reg.top    > rd_entry.top)    ? cur_reg.top    : rd_entry.top;
    assign ov_r = (cur_reg.right  < rd_entry.right)  ? cur_reg.right  : rd_entry.right;
    assign ov_b = (cur_reg.bottom < rd_entry.bottom) ? cur_reg.bottom : rd_entry.bottom;
    assign pair_hit = (cur_reg.cls == rd_entry.cls) && (ov_l < ov_r) && (ov_t < ov_b);

    assign rd_w = $signed({1'b0, rd_entry.right})  - $signed({1'b0, rd_entry.left});
    assign rd_h = $signed({1'b0, rd_entry.bottom}) - $signed({1'b0, rd_entry.top});

    always_comb begin
        if (state_reg == ST_J_AREA) begin
            mul_a = $signed({1'b0, iw_reg});
            mul_b = $signed({1'b0, ih_reg});
        end else begin
            mul_a = rd_w;
            mul_b = rd_h;
        end
    end

    cabn_mul #(
        .W(DIM_W)
    ) u_mul (
        .aclk  (aclk),
        .mul_a (mul_a),
        .mul_b (mul_b),
        .mul_p (mul_p)
    );

    assign uni      = U_W'(area_i_reg) + U_W'(area_j_reg) - U_W'(mul_p);
    assign inter2   = U_W'(mul_p) <<< 1;
    assign suppress = (uni == U_W'(0)) || (!uni[U_W-1] && (inter2 > uni));

    assign out_free = !m_valid_reg || m_ready;
    assign m_load   = out_free && ((state_reg == ST_E_OUT) || (state_reg == ST_E_EMPTY));
    assign live_ext = LIM_W'(live_reg);
    assign emit_lim = (live_ext > LIM_W'(RESULT_LIMIT)) ? LIM_W'(RESULT_LIMIT) : live_ext;
    assign n_inc    = n_reg + LIM_W'(1);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD: begin
                if (s_accept && s_last_item) begin
                    state_next = ST_I_START;
                end
            end
            ST_I_START: begin
                if (i_reg >= kept_reg) begin
                    state_next = ST_E_SCAN;
                end else if (alive_reg[i_reg[IDX_W-1:0]]) begin
                    state_next = ST_I_LOAD;
                end
            end
            ST_I_LOAD: state_next = ST_I_AREA;
            ST_I_AREA: state_next = ST_J_SEL;
            ST_J_SEL: begin
                if (CNT_W'(j_reg) <= i_reg) begin
                    state_next = ST_I_END;
                end else if (alive_reg[j_reg]) begin
                    state_next = ST_J_CHK;
                end
            end
            ST_J_CHK:  state_next = pair_hit ? ST_J_AREA : ST_J_SEL;
            ST_J_AREA: state_next = ST_J_INT;
            ST_J_INT:  state_next = ST_J_SEL;
            ST_I_END:  state_next = ST_I_START;
            ST_E_SCAN: begin
                if (n_reg == emit_lim) begin
                    state_next = (live_reg == '0) ? ST_E_EMPTY : ST_LOAD;
                end else if (alive_reg[k_reg[IDX_W-1:0]]) begin
                    state_next = ST_E_OUT;
                end
            end
            ST_E_OUT: begin
                if (out_free) begin
                    state_next = ST_E_SCAN;
                end
            end
            ST_E_EMPTY: begin
                if (out_free) begin
                    state_next = ST_LOAD;
                end
            end
            default: state_next = ST_LOAD;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_LOAD;
            thresh_reg   <= THRESH_RESET;
            kept_reg     <= '0;
            arrival_reg  <= '0;
            overflow_reg <= 1'b0;
            alive_reg    <= '0;
            live_reg     <= '0;
            i_reg        <= '0;
            j_reg        <= '0;
            k_reg        <= '0;
            n_reg        <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;

            if (cfg_we) begin
                thresh_reg <= cfg_wdata;
            end

            if (m_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_LOAD: begin
                    if (s_accept) begin
                        if (arrival_reg != ARRIVAL_MAX) begin
                            arrival_reg <= arrival_reg + ARR_W'(1);
                        end
                        if (store_box) begin
                            alive_reg[kept_reg[IDX_W-1:0]] <= 1'b1;
                            kept_reg <= kept_inc;
                        end else if (keep_box) begin
                            overflow_reg <= 1'b1;
                        end
                        live_reg <= kept_inc;
                        i_reg    <= '0;
                    end
                end
                ST_I_START: begin
                    if (i_reg >= kept_reg) begin
                        k_reg <= '0;
                        n_reg <= '0;
                    end else if (!alive_reg[i_reg[IDX_W-1:0]]) begin
                        i_reg <= i_reg + CNT_W'(1);
                    end
                end
                ST_I_LOAD: begin
                    j_reg <= IDX_W'(kept_reg - CNT_W'(1));
                end
                ST_J_SEL: begin
                    if ((CNT_W'(j_reg) > i_reg) && !alive_reg[j_reg]) begin
                        j_reg <= j_reg - IDX_W'(1);
                    end
                end
                ST_J_CHK: begin
                    if (!pair_hit) begin
                        j_reg <= j_reg - IDX_W'(1);
                    end
                end
                ST_J_INT: begin
                    if (suppress) begin
                        alive_reg[j_reg] <= 1'b0;
                        live_reg         <= live_reg - CNT_W'(1);
                    end
                    j_reg <= j_reg - IDX_W'(1);
                end
                ST_I_END: begin
                    i_reg <= i_reg + CNT_W'(1);
                end
                ST_E_SCAN: begin
                    if (n_reg == emit_lim) begin
                        if (live_reg != '0) begin
                            kept_reg     <= '0;
                            arrival_reg  <= '0;
                            overflow_reg <= 1'b0;
                            alive_reg    <= '0;
                        end
                    end else if (!alive_reg[k_reg[IDX_W-1:0]]) begin
                        k_reg <= k_reg + CNT_W'(1);
                    end
                end
                ST_E_OUT: begin
                    if (out_free) begin
                        n_reg       <= n_inc;
                        k_reg       <= k_reg + CNT_W'(1);
                    end
                end
                ST_E_EMPTY: begin
                    if (out_free) begin
                        kept_reg     <= '0;
                        arrival_reg  <= '0;
                        overflow_reg <= 1'b0;
                        alive_reg    <= '0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_I_LOAD: begin
                cur_reg <= rd_entry;
            end
            ST_I_AREA: begin
                area_i_reg <= mul_p;
            end
            ST_J_CHK: begin
                jd_reg <= rd_entry;
                iw_reg <= ov_r - ov_l;
                ih_reg <= ov_b - ov_t;
            end
            ST_J_AREA: begin
                area_j_reg <= mul_p;
            end
            ST_J_INT: begin
                if (suppress && (cur_reg.score < jd_reg.score)) begin
                    cur_reg    <= jd_reg;
                    area_i_reg <= area_j_reg;
                end
            end
            ST_E_OUT: begin
                if (out_free) begin
                    m_entry_reg        <= rd_entry;
                    m_result_valid_reg <= 1'b1;
                    m_last_reg         <= (n_inc == emit_lim);
                    m_ovf_reg          <= overflow_reg;
                end
            end
            ST_E_EMPTY: begin
                if (out_free) begin
                    m_entry_reg        <= '0;
                    m_result_valid_reg <= 1'b0;
                    m_last_reg         <= 1'b1;
                    m_ovf_reg          <= overflow_reg;
                end
            end
            default: begin
            end
        endcase
    end

    assign m_valid          = m_valid_reg;
    assign m_result_valid   = m_result_valid_reg;
    assign m_arrival_index  = m_entry_reg.idx;
    assign m_out_class      = m_entry_reg.cls;
    assign m_out_left       = m_entry_reg.left;
    assign m_out_top        = m_entry_reg.top;
    assign m_out_right      = m_entry_reg.right;
    assign m_out_bottom     = m_entry_reg.bottom;
    assign m_out_confidence = m_entry_reg.score;
    assign m_last_result    = m_last_reg;
    assign m_overflow       = m_ovf_reg;

endmodule

>>> sim/tb_class_aware_box_nms_core.sv
`timescale 1ns / 1ps
// Self-checking testbench for the class-aware box suppression core with a built-in predictor.
module tb_class_aware_box_nms_core;
    import cabn_pkg::*;

    localparam int     MAX_BOXES   = 64;
    localparam int     COORD_BITS  = 12;
    localparam int     BULK_ITEMS  = 410;
    localparam longint CYCLE_LIMIT = 4_000_000;

    typedef logic [COORD_BITS-1:0] coord_t;

    typedef struct packed {
        logic [CLASS_W-1:0] cls;
        coord_t             left;
        coord_t             top;
        coord_t             right;
        coord_t             bottom;
        logic [SCORE_W-1:0] conf;
        logic               last;
    } box_t;

    typedef struct packed {
        logic               hit;
        logic [ARR_W-1:0]   arrival;
        logic [CLASS_W-1:0] cls;
        coord_t             left;
        coord_t             top;
        coord_t             right;
        coord_t             bottom;
        logic [SCORE_W-1:0] conf;
        logic               last;
        logic               ovf;
    } survivor_t;

    class nms_scoreboard;
        logic [SCORE_W-1:0] threshold;
        box_t               slot [MAX_BOXES];
        logic [ARR_W-1:0]   slot_arrival [MAX_BOXES];
        bit                 alive [MAX_BOXES];
        int                 kept;
        int                 arrivals;
        bit                 spilled;
        survivor_t          survivors [$];
        int                 errors;
        int                 boxes;
        int                 sets;
        int                 results;
        int                 merges;
        int                 spill_sets;
        int                 empty_sets;

        function new();
            threshold = THRESH_RESET;
            clear_set();
        endfunction

        function void clear_set();
            foreach (alive[k]) alive[k] = 1'b0;
            kept     = 0;
            arrivals = 0;
            spilled  = 1'b0;
        endfunction

        function longint area(box_t b);
            return (longint'(b.right) - longint'(b.left)) * (longint'(b.bottom) - longint'(b.top));
        endfunction

        function bit overlaps(box_t a, box_t b);
            longint l, t, r, btm, inter, uni;
            l   = (a.left > b.left) ? a.left : b.left;
            t   = (a.top > b.top) ? a.top : b.top;
            r   = (a.right < b.right) ? a.right : b.right;
            btm = (a.bottom < b.bottom) ? a.bottom : b.bottom;
            if (l >= r || t >= btm) return 1'b0;
            inter = (r - l) * (btm - t);
            uni   = area(a) + area(b) - inter;
            if (uni == 0) return 1'b1;
            return uni > 0 && 2 * inter > uni;
        endfunction

        function void note_request(box_t b);
            logic [ARR_W-1:0] idx;
            survivor_t        s;
            int               n;
            idx = arrivals[ARR_W-1:0];
            if (arrivals < ARRIVAL_MAX) arrivals++;
            boxes++;
            if (b.conf >= threshold) begin
                if (kept < MAX_BOXES) begin
                    slot[kept]         = b;
                    slot_arrival[kept] = idx;
                    alive[kept]        = 1'b1;
                    kept++;
                end else begin
                    spilled = 1'b1;
                end
            end
            if (!b.last) return;

            for (int i = 0; i < kept; i++) begin
                if (!alive[i]) continue;
                for (int j = kept - 1; j > i; j--) begin
                    if (!alive[j] || slot[i].cls != slot[j].cls) continue;
                    if (!overlaps(slot[i], slot[j])) continue;
                    if (slot[i].conf < slot[j].conf) begin
                        slot[i]         = slot[j];
                        slot_arrival[i] = slot_arrival[j];
                    end
                    alive[j] = 1'b0;
                    merges++;
                end
            end

            n = 0;
            for (int i = 0; i < kept && n < RESULT_LIMIT; i++) begin
                if (!alive[i]) continue;
                s = '{hit: 1'b1, arrival: slot_arrival[i], cls: slot[i].cls,
                      left: slot[i].left, top: slot[i].top, right: slot[i].right,
                      bottom: slot[i].bottom, conf: slot[i].conf, last: 1'b0, ovf: spilled};
                survivors.push_back(s);
                n++;
            end
            if (n == 0) begin
                s     = '0;
                s.ovf = spilled;
                survivors.push_back(s);
                empty_sets++;
            end
            survivors[survivors.size() - 1].last = 1'b1;
            if (spilled) spill_sets++;
            sets++;
            clear_set();
        endfunction

        function void compare(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                errors++;
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            end
        endfunction

        function void check_result(survivor_t got);
            survivor_t want;
            if (survivors.size() == 0) begin
                errors++;
                $display("%0t: result with none expected, expected nothing, actual %0h",
                         $time, got);
                return;
            end
            want = survivors.pop_front();
            results++;
            compare("m_result_valid", 32'(want.hit), 32'(got.hit));
            compare("m_arrival_index", 32'(want.arrival), 32'(got.arrival));
            compare("m_out_class", 32'(want.cls), 32'(got.cls));
            compare("m_out_left", 32'(want.left), 32'(got.left));
            compare("m_out_top", 32'(want.top), 32'(got.top));
            compare("m_out_right", 32'(want.right), 32'(got.right));
            compare("m_out_bottom", 32'(want.bottom), 32'(got.bottom));
            compare("m_out_confidence", 32'(want.conf), 32'(got.conf));
            compare("m_last_result", 32'(want.last), 32'(got.last));
            compare("m_overflow", 32'(want.ovf), 32'(got.ovf));
        endfunction
    endclass

    logic               aclk         = 1'b0;
    logic               aresetn      = 1'b0;
    logic               cfg_we       = 1'b0;
    logic [SCORE_W-1:0] cfg_wdata    = '0;
    logic               s_valid      = 1'b0;
    logic               s_ready;
    logic [CLASS_W-1:0] s_class_id   = '0;
    coord_t             s_box_left   = '0;
    coord_t             s_box_top    = '0;
    coord_t             s_box_right  = '0;
    coord_t             s_box_bottom = '0;
    logic [SCORE_W-1:0] s_confidence = '0;
    logic               s_last_item  = 1'b0;
    logic               m_valid;
    logic               m_ready      = 1'b0;
    logic               m_result_valid;
    logic [ARR_W-1:0]   m_arrival_index;
    logic [CLASS_W-1:0] m_out_class;
    coord_t             m_out_left;
    coord_t             m_out_top;
    coord_t             m_out_right;
    coord_t             m_out_bottom;
    logic [SCORE_W-1:0] m_out_confidence;
    logic               m_last_result;
    logic               m_overflow;

    nms_scoreboard sb;
    bit            tx_calm  = 1'b0;
    bit            rx_calm  = 1'b0;
    int            rx_hold  = 0;
    int            rx_phase = 0;
    longint        cycles   = 0;

    always #5 aclk = ~aclk;

    class_aware_box_nms_core #(
        .MAX_BOXES  (MAX_BOXES),
        .COORD_BITS (COORD_BITS)
    ) i_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_we           (cfg_we),
        .cfg_wdata        (cfg_wdata),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_class_id       (s_class_id),
        .s_box_left       (s_box_left),
        .s_box_top        (s_box_top),
        .s_box_right      (s_box_right),
        .s_box_bottom     (s_box_bottom),
        .s_confidence     (s_confidence),
        .s_last_item      (s_last_item),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_result_valid   (m_result_valid),
        .m_arrival_index  (m_arrival_index),
        .m_out_class      (m_out_class),
        .m_out_left       (m_out_left),
        .m_out_top        (m_out_top),
        .m_out_right      (m_out_right),
        .m_out_bottom     (m_out_bottom),
        .m_out_confidence (m_out_confidence),
        .m_last_result    (m_last_result),
        .m_overflow       (m_overflow)
    );

    function automatic int idle_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 70) return $urandom_range(1, 2);
        if (p < 95) return $urandom_range(3, 8);
        return $urandom_range(20, 60);
    endfunction

    function automatic coord_t clamp(int v);
        if (v < 0) return '0;
        if (v > 4095) return '1;
        return v[COORD_BITS-1:0];
    endfunction

    function automatic box_t mk(int cls, int l, int t, int r, int b, int conf, bit last);
        box_t x;
        x.cls    = cls[CLASS_W-1:0];
        x.left   = l[COORD_BITS-1:0];
        x.top    = t[COORD_BITS-1:0];
        x.right  = r[COORD_BITS-1:0];
        x.bottom = b[COORD_BITS-1:0];
        x.conf   = conf[SCORE_W-1:0];
        x.last   = last;
        return x;
    endfunction

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t: watchdog expired after %0d cycles", $time, cycles);
            $display("tb_class_aware_box_nms_core: errors");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (rx_phase == 0) begin
            rx_calm  <= ($urandom_range(0, 3) == 0);
            rx_phase <= $urandom_range(50, 400);
        end else begin
            rx_phase <= rx_phase - 1;
        end
        if (rx_hold > 0) begin
            m_ready <= 1'b0;
            rx_hold <= rx_hold - 1;
        end else if (!rx_calm && $urandom_range(0, 99) < 30) begin
            m_ready <= 1'b0;
            rx_hold <= idle_len() - 1;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result({m_result_valid, m_arrival_index, m_out_class, m_out_left,
                             m_out_top, m_out_right, m_out_bottom, m_out_confidence,
                             m_last_result, m_overflow});
    end

    task automatic send_box(box_t b);
        int gap;
        gap = (tx_calm || $urandom_range(0, 99) < 55) ? 0 : idle_len();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_class_id   <= b.cls;
        s_box_left   <= b.left;
        s_box_top    <= b.top;
        s_box_right  <= b.right;
        s_box_bottom <= b.bottom;
        s_confidence <= b.conf;
        s_last_item  <= b.last;
        do @(posedge aclk); while (!s_ready);
        sb.note_request(b);
    endtask

    task automatic set_threshold(logic [SCORE_W-1:0] v);
        s_valid <= 1'b0;
        while (sb.survivors.size() != 0) @(posedge aclk);
        // let the output stage hand back to loading
        repeat (8) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we       <= 1'b0;
        sb.threshold  = v;
    endtask

    task automatic random_set(int n);
        int   ax [3];
        int   ay [3];
        int   aw [3];
        int   ah [3];
        int   acls [3];
        int   a;
        int   p;
        box_t b;
        for (int k = 0; k < 3; k++) begin
            ax[k]   = $urandom_range(0, 3900);
            ay[k]   = $urandom_range(0, 3900);
            aw[k]   = $urandom_range(1, 300);
            ah[k]   = $urandom_range(1, 300);
            acls[k] = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 2) : $urandom_range(0, 255);
        end
        tx_calm = ($urandom_range(0, 3) == 0);
        for (int k = 0; k < n; k++) begin
            p = $urandom_range(0, 99);
            if (p < 75) begin
                a        = $urandom_range(0, 2);
                b.cls    = CLASS_W'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 255)
                                                                : acls[a]);
                b.left   = clamp(ax[a] + $urandom_range(0, 40) - 20);
                b.top    = clamp(ay[a] + $urandom_range(0, 40) - 20);
                b.right  = clamp(ax[a] + aw[a] + $urandom_range(0, 40) - 20);
                b.bottom = clamp(ay[a] + ah[a] + $urandom_range(0, 40) - 20);
            end else begin
                b.cls    = CLASS_W'($urandom_range(0, 255));
                b.left   = coord_t'($urandom_range(0, 4095));
                b.top    = coord_t'($urandom_range(0, 4095));
                b.right  = coord_t'($urandom_range(0, 4095));
                b.bottom = coord_t'($urandom_range(0, 4095));
            end
            if ($urandom_range(0, 99) < 80)
                b.conf = SCORE_W'($urandom_range(16'hFFFF, sb.threshold));
            else
                b.conf = SCORE_W'($urandom_range(0, 16'hFFFF));
            b.last = (k == n - 1);
            send_box(b);
        end
    endtask

    function automatic logic [SCORE_W-1:0] pick_threshold();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return THRESH_RESET;
            3: return SCORE_W'($urandom_range(0, 2000));
            default: return SCORE_W'($urandom_range(0, 16'hFFFF));
        endcase
    endfunction

    initial begin
        int items;
        int n;
        int p;
        bit spill_done;
        sb = new();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty set at the reset threshold, all-ones fields
        tx_calm = 1'b0;
        send_box(mk(255, 4095, 4095, 4095, 4095, THRESH_RESET - 1, 1'b1));

        send_box(mk(0, 0, 0, 0, 0, int'(THRESH_RESET), 1'b0));
        send_box(mk(255, 4095, 4095, 4095, 4095, 65535, 1'b0));
        send_box(mk(7, 0, 0, 3, 1, 40000, 1'b0));
        send_box(mk(7, 1, 0, 4, 1, 50000, 1'b0));
        send_box(mk(9, 100, 100, 200, 200, 40000, 1'b0));
        send_box(mk(9, 105, 102, 198, 203, 60000, 1'b0));
        send_box(mk(10, 100, 100, 200, 200, 40000, 1'b0));
        send_box(mk(9, 300, 300, 400, 400, 45000, 1'b0));
        send_box(mk(9, 300, 300, 400, 400, 45000, 1'b0));
        send_box(mk(3, 200, 200, 100, 100, 50000, 1'b0));
        send_box(mk(3, 90, 90, 210, 210, 50000, 1'b0));
        send_box(mk(5, 0, 0, 4095, 4095, 30000, 1'b1));

        set_threshold('0);
        send_box(mk(8'h55, 12'h555, 12'h555, 12'hAAA, 12'hAAA, 0, 1'b0));
        send_box(mk(8'hAA, 12'hAAA, 12'hAAA, 12'h555, 12'h555, 16'h5555, 1'b0));
        send_box(mk(8'h55, 12'h556, 12'h554, 12'hAA9, 12'hAAB, 16'hAAAA, 1'b1));

        set_threshold('1);
        send_box(mk(1, 10, 10, 20, 20, 65534, 1'b0));
        send_box(mk(1, 12, 12, 22, 22, 65535, 1'b1));

        items      = 0;
        spill_done = 1'b0;
        set_threshold(THRESH_RESET);
        while (items < BULK_ITEMS) begin
            if (!spill_done && items > 120) begin
                set_threshold('0);
                random_set(72);
                items      += 72;
                spill_done  = 1'b1;
            end
            if ($urandom_range(0, 7) == 0) set_threshold(pick_threshold());
            p = $urandom_range(0, 99);
            if (p < 80)
                n = $urandom_range(1, 10);
            else if (p < 95)
                n = $urandom_range(11, 30);
            else
                n = $urandom_range(40, 100);
            random_set(n);
            items += n;
        end

        s_valid <= 1'b0;
        while (sb.survivors.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);

        $display("run: %0d boxes in %0d sets, %0d results checked", sb.boxes, sb.sets, sb.results);
        $display("run: %0d suppressions, %0d sets with overflow, %0d sets with no survivor",
                 sb.merges, sb.spill_sets, sb.empty_sets);
        if (sb.errors == 0)
            $display("tb_class_aware_box_nms_core: clean");
        else
            $display("tb_class_aware_box_nms_core: errors");
        $finish;
    end

endmodule

>>> filelist.f
rtl/cabn_pkg.sv
rtl/cabn_ram.sv
rtl/cabn_mul.sv
rtl/class_aware_box_nms_core.sv
sim/tb_class_aware_box_nms_core.sv
